// ===== rtl/iupy_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the IMU frame parser with yaw unwrap.
// No dependencies; used by every module of the block.
package iupy_pkg;

  // Frame framing bytes
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_GYRO   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;
  localparam logic [7:0] TYPE_QUAT   = 8'h59;

  // Result kind codes
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;
  localparam logic [1:0] KIND_QUAT  = 2'd3;

  // Byte positions within a frame (bytes held so far)
  localparam logic [3:0] POS_HUNT  = 4'd0;
  localparam logic [3:0] POS_TYPE  = 4'd1;
  localparam logic [3:0] POS_DATA0 = 4'd2;
  localparam logic [3:0] POS_CSUM  = 4'd10;

  // Depth of the queue between parser and unwrap stage
  localparam int FQ_DEPTH = 4;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
  } kind_lookup_t;

  // One parsed frame handed from the front to the back
  typedef struct packed {
    logic [1:0]         kind;
    logic               good;
    logic signed [15:0] word_a;
    logic signed [15:0] word_b;
    logic signed [15:0] word_c;
    logic signed [15:0] word_d;
  } frame_t;

  function automatic kind_lookup_t kind_of(input logic [7:0] t);
    kind_lookup_t r;
    r.valid = 1'b1;
    r.kind  = KIND_ACCEL;
    case (t)
      TYPE_ACCEL: r.kind = KIND_ACCEL;
      TYPE_GYRO:  r.kind = KIND_GYRO;
      TYPE_ANGLE: r.kind = KIND_ANGLE;
      TYPE_QUAT:  r.kind = KIND_QUAT;
      default:    r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/iupy_front.sv =====
`timescale 1ns / 1ps
// Byte-level frame parser: hunts headers, checks types, sums the checksum.
// Depends on iupy_pkg; pushes completed frames into iupy_fq.
module iupy_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [7:0]            rx_byte,
  input  logic                  q_full,
  output logic                  full,
  output logic                  q_wr,
  output iupy_pkg::frame_t      q_data
);

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [7:0] sum;
  logic [7:0] sum_next;
  logic [1:0] kind;
  logic [1:0] kind_next;
  logic [7:0] data [0:7];
  logic       take;
  logic [2:0] data_idx;
  iupy_pkg::kind_lookup_t lk;

  assign full     = q_full;
  assign take     = push && !q_full;
  assign lk       = iupy_pkg::kind_of(rx_byte);
  assign data_idx = 3'(pos - iupy_pkg::POS_DATA0);

  always_comb begin
    pos_next  = pos;
    sum_next  = sum;
    kind_next = kind;
    q_wr      = 1'b0;
    if (take) begin
      if (pos == iupy_pkg::POS_HUNT || pos > iupy_pkg::POS_CSUM) begin
        pos_next = (rx_byte == iupy_pkg::HEADER_BYTE) ? iupy_pkg::POS_TYPE
                                                       : iupy_pkg::POS_HUNT;
        sum_next = iupy_pkg::HEADER_BYTE;
      end else if (pos == iupy_pkg::POS_TYPE) begin
        if (lk.valid) begin
          pos_next  = iupy_pkg::POS_DATA0;
          sum_next  = sum + rx_byte;
          kind_next = lk.kind;
        end else begin
          // unsupported type: a header byte restarts a frame
          pos_next = (rx_byte == iupy_pkg::HEADER_BYTE) ? iupy_pkg::POS_TYPE
                                                         : iupy_pkg::POS_HUNT;
          sum_next = iupy_pkg::HEADER_BYTE;
        end
      end else if (pos == iupy_pkg::POS_CSUM) begin
        q_wr     = 1'b1;
        pos_next = (rx_byte == iupy_pkg::HEADER_BYTE) ? iupy_pkg::POS_TYPE
                                                       : iupy_pkg::POS_HUNT;
        sum_next = iupy_pkg::HEADER_BYTE;
      end else begin
        pos_next = pos + 4'd1;
        sum_next = sum + rx_byte;
      end
    end
  end

  always_comb begin
    q_data.kind   = kind;
    q_data.good   = (sum == rx_byte);
    q_data.word_a = {data[1], data[0]};
    q_data.word_b = {data[3], data[2]};
    q_data.word_c = {data[5], data[4]};
    q_data.word_d = {data[7], data[6]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= iupy_pkg::POS_HUNT;
      sum  <= iupy_pkg::HEADER_BYTE;
      kind <= iupy_pkg::KIND_ACCEL;
    end else begin
      pos  <= pos_next;
      sum  <= sum_next;
      kind <= kind_next;
    end
  end

  // hold data bytes in place by position
  always_ff @(posedge clk) begin
    if (take && pos >= iupy_pkg::POS_DATA0 && pos < iupy_pkg::POS_CSUM) begin
      data[data_idx] <= rx_byte;
    end
  end

endmodule

// ===== rtl/iupy_fq.sv =====
`timescale 1ns / 1ps
// Short frame queue decoupling the parser from the unwrap stage.
// Depends on iupy_pkg for the frame record and queue depth.
module iupy_fq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  iupy_pkg::frame_t wr_data,
  input  logic             rd,
  output iupy_pkg::frame_t rd_data,
  output logic             not_empty,
  output logic             q_full
);

  localparam int PW = $clog2(iupy_pkg::FQ_DEPTH);
  localparam int CW = $clog2(iupy_pkg::FQ_DEPTH + 1);

  iupy_pkg::frame_t mem [0:iupy_pkg::FQ_DEPTH-1];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          do_wr;
  logic          do_rd;

  assign q_full    = (cnt == CW'(iupy_pkg::FQ_DEPTH));
  assign not_empty = (cnt != '0);
  assign do_wr     = wr && !q_full;
  assign do_rd     = rd && not_empty;
  assign rd_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= (wp == PW'(iupy_pkg::FQ_DEPTH - 1)) ? '0 : wp + PW'(1);
      if (do_rd) rp <= (rp == PW'(iupy_pkg::FQ_DEPTH - 1)) ? '0 : rp + PW'(1);
      if (do_wr && !do_rd) cnt <= cnt + CW'(1);
      else if (do_rd && !do_wr) cnt <= cnt - CW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(iupy_pkg::FQ_DEPTH))
    else $error("frame queue count above depth");

  a_rd_advances: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> (cnt == $past(cnt) - CW'(1)))
    else $error("frame queue read did not drop count");

endmodule

// ===== rtl/iupy_back.sv =====
`timescale 1ns / 1ps
// Back stage: frame counters, yaw unwrap and the result output register.
// Depends on iupy_pkg; fed by iupy_fq.
module iupy_back #(
  parameter int COUNT_BITS = 16,
  parameter int YAW_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  iupy_pkg::frame_t   q_data,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output logic [1:0]         frame_kind,
  output logic               checksum_good,
  output logic signed [15:0] word_a,
  output logic signed [15:0] word_b,
  output logic signed [15:0] word_c,
  output logic signed [15:0] word_d,
  output logic               yaw_updated,
  output logic signed [31:0] yaw_continuous,
  output logic [15:0]        good_frames,
  output logic [15:0]        bad_frames
);

  logic                  out_valid;
  logic                  angle_seen;
  logic                  angle_seen_next;
  logic [15:0]           last_yaw;
  logic [15:0]           last_yaw_next;
  logic [YAW_BITS-1:0]   acc;
  logic [YAW_BITS-1:0]   acc_next;
  logic [COUNT_BITS-1:0] good_count;
  logic [COUNT_BITS-1:0] good_count_next;
  logic [COUNT_BITS-1:0] bad_count;
  logic [COUNT_BITS-1:0] bad_count_next;
  logic                  upd;
  logic [15:0]           yaw;
  logic [15:0]           delta;
  logic [YAW_BITS+31:0]  acc_wide;
  logic [COUNT_BITS+15:0] good_wide;
  logic [COUNT_BITS+15:0] bad_wide;

  assign q_rd  = q_valid && (!out_valid || pop);
  assign empty = !out_valid;
  assign yaw   = q_data.word_c;
  assign delta = yaw - last_yaw;
  assign upd   = q_data.good && (q_data.kind == iupy_pkg::KIND_ANGLE);

  always_comb begin
    good_count_next = good_count;
    bad_count_next  = bad_count;
    acc_next        = acc;
    last_yaw_next   = last_yaw;
    angle_seen_next = angle_seen;
    if (q_data.good) good_count_next = good_count + COUNT_BITS'(1);
    else             bad_count_next  = bad_count + COUNT_BITS'(1);
    if (upd) begin
      if (angle_seen) acc_next = acc + {{(YAW_BITS-16){delta[15]}}, delta};
      else            acc_next = {{(YAW_BITS-16){yaw[15]}}, yaw};
      last_yaw_next   = yaw;
      angle_seen_next = 1'b1;
    end
  end

  assign acc_wide  = {32'b0, acc_next};
  assign good_wide = {16'b0, good_count_next};
  assign bad_wide  = {16'b0, bad_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      angle_seen <= 1'b0;
      last_yaw   <= '0;
      acc        <= '0;
      good_count <= '0;
      bad_count  <= '0;
    end else begin
      if (q_rd) begin
        out_valid  <= 1'b1;
        angle_seen <= angle_seen_next;
        last_yaw   <= last_yaw_next;
        acc        <= acc_next;
        good_count <= good_count_next;
        bad_count  <= bad_count_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (q_rd) begin
      frame_kind     <= q_data.kind;
      checksum_good  <= q_data.good;
      word_a         <= q_data.word_a;
      word_b         <= q_data.word_b;
      word_c         <= q_data.word_c;
      word_d         <= q_data.word_d;
      yaw_updated    <= upd;
      yaw_continuous <= acc_wide[31:0];
      good_frames    <= good_wide[15:0];
      bad_frames     <= bad_wide[15:0];
    end
  end

  a_upd_is_good_angle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && yaw_updated) |->
      (checksum_good && frame_kind == iupy_pkg::KIND_ANGLE))
    else $error("yaw update flagged on a non-angle or bad frame");

  a_bad_counts: assert property (@(posedge clk) disable iff (rst)
    (q_rd && !q_data.good) |=> (bad_count == $past(bad_count) + COUNT_BITS'(1)))
    else $error("bad frame not counted");

  a_seen_sticks: assert property (@(posedge clk) disable iff (rst)
    angle_seen |=> angle_seen)
    else $error("angle seed flag dropped");

endmodule

// ===== rtl/imu_frame_parser_yaw_unwrap.sv =====
`timescale 1ns / 1ps
// IMU frame parser with yaw unwrap: top level. Depends on iupy_pkg, iupy_front,
// iupy_fq and iupy_back.
//
// Feed received serial bytes through push/full, one byte per clock at full
// rate. The parser hunts for the 0x55 header, accepts type bytes 0x51 (accel),
// 0x52 (gyro), 0x53 (angle) and 0x59 (quaternion), collects eight data bytes
// and checks the 8-bit sum in the eleventh byte. An unsupported type byte or a
// finished frame restarts the hunt, and a 0x55 in that place is taken as the
// next header. Each completed frame yields one request on the result side
// (empty/pop): its kind, checksum status, the four little-endian signed words
// and running good/bad frame counts. Good angle frames unwrap the yaw word into
// a wrapping accumulator of 65536 units per turn; the first one seeds it and a
// half-turn step counts as -180 degrees. The input takes one byte per cycle; the
// edge that takes a checksum byte writes the frame into the queue, and the
// unwrap stage loads it from there into the result register, behind any
// earlier frames, once that register is free. Input stalls only while the
// four-entry frame queue between parser and unwrap stage is full, which needs
// the result side to hold off pop for several frames.
module imu_frame_parser_yaw_unwrap #(
  parameter int COUNT_BITS = 16,
  parameter int YAW_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               push,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         frame_kind,
  output logic               checksum_good,
  output logic signed [15:0] word_a,
  output logic signed [15:0] word_b,
  output logic signed [15:0] word_c,
  output logic signed [15:0] word_d,
  output logic               yaw_updated,
  output logic signed [31:0] yaw_continuous,
  output logic [15:0]        good_frames,
  output logic [15:0]        bad_frames
);

  // parser -> queue
  logic             fq_wr;
  iupy_pkg::frame_t fq_wr_data;
  logic             fq_full;
  // queue -> unwrap stage
  logic             fq_rd;
  iupy_pkg::frame_t fq_rd_data;
  logic             fq_not_empty;

  // Front: accept bytes, classify and checksum frames
  iupy_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .q_full  (fq_full),
    .full    (full),
    .q_wr    (fq_wr),
    .q_data  (fq_wr_data)
  );

  // Queue: let parser and result side stall independently
  iupy_fq u_fq (
    .clk       (clk),
    .rst       (rst),
    .wr        (fq_wr),
    .wr_data   (fq_wr_data),
    .rd        (fq_rd),
    .rd_data   (fq_rd_data),
    .not_empty (fq_not_empty),
    .q_full    (fq_full)
  );

  // Back: count frames, unwrap yaw, hold the result until popped
  iupy_back #(
    .COUNT_BITS (COUNT_BITS),
    .YAW_BITS   (YAW_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (fq_not_empty),
    .q_data         (fq_rd_data),
    .q_rd           (fq_rd),
    .pop            (pop),
    .empty          (empty),
    .frame_kind     (frame_kind),
    .checksum_good  (checksum_good),
    .word_a         (word_a),
    .word_b         (word_b),
    .word_c         (word_c),
    .word_d         (word_d),
    .yaw_updated    (yaw_updated),
    .yaw_continuous (yaw_continuous),
    .good_frames    (good_frames),
    .bad_frames     (bad_frames)
  );

endmodule
